// ===== rtl/core/assert_macros.svh =====
// Assertion shorthands used by the checker file ola_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define AST_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: label");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define AST_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: label");

`endif

// ===== rtl/core/ola_pkg.sv =====
`default_nettype none

package ola_pkg;

	localparam int unsigned DATA_W = 32;

	// Command codes
	typedef enum logic [1:0] {
		CMD_APPEND = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_SHOW   = 2'd2,
		CMD_RSVD   = 2'd3
	} ola_cmd_t;

	// Status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_EMPTY     = 2'd3
	} ola_status_t;

	// Input beat
	typedef struct packed {
		logic [1:0]               command;
		logic signed [DATA_W-1:0] value;
	} ola_in_t;

	// Output beat
	typedef struct packed {
		logic signed [DATA_W-1:0] item;
		logic [1:0]               status;
		logic                     last;
	} ola_out_t;

	// Broadcast control for the cell chain
	typedef struct packed {
		logic              shift;
		logic              load;
		logic [DATA_W-1:0] data;
	} ola_cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/ola_cell.sv =====
`default_nettype none

module ola_cell #(
	parameter int unsigned IDX   = 0,
	parameter int unsigned CNT_W = 5
) (
	input  logic                          clk,
	input  ola_pkg::ola_cell_ctrl_t       ctrl,
	input  logic [CNT_W-1:0]              load_idx,
	input  logic [ola_pkg::DATA_W-1:0]    right,
	output logic [ola_pkg::DATA_W-1:0]    q
);
	import ola_pkg::*;

	logic [DATA_W-1:0] data_q;

	// Load from the bus when addressed, else take the right neighbor on a shift
	always_ff @(posedge clk) begin
		if (ctrl.load && (load_idx == CNT_W'(IDX))) begin
			data_q <= ctrl.data;
		end else if (ctrl.shift) begin
			data_q <= right;
		end
	end

	assign q = data_q;

endmodule

`default_nettype wire

// ===== rtl/core/ordered_list_append_delete.sv =====
// Append, and delete or show on an empty list, give their beat in the cycle after accept.
// Delete walks the chain once, then gives its result beat; no new command is accepted until the walk ends.
// Show walks the chain and emits one beat per cycle, count beats in all.
// Throughput: append one per cycle while results are not stalled; delete and show hold the input until the walk ends.
// A stalled result beat pauses the walk and the input for as long as it stalls.
// Reset (arst_n low, async) empties the list; entry cells are not cleared.
`default_nettype none

module ordered_list_append_delete #(
	parameter int unsigned DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  ola_pkg::ola_in_t  cmd,
	output logic              res_valid,
	input  logic              res_stall,
	output ola_pkg::ola_out_t res
);
	import ola_pkg::*;

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DEL  = 3'b010,
		S_SHOW = 3'b100
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  len_q;
	logic [CNT_W-1:0]  steps_q;
	logic              hit_q;
	logic [DATA_W-1:0] key_q;
	logic              res_valid_q;
	ola_out_t          res_q;

	logic              out_free;
	logic              cmd_acc;
	logic              walk;
	logic              last_step;
	logic              match;
	logic [DATA_W-1:0] head;
	logic [CNT_W-1:0]  len_next;
	logic              full;
	ola_cell_ctrl_t    cell_ctrl;
	logic [CNT_W-1:0]  load_idx;
	logic              new_valid;
	ola_out_t          new_res;

	logic [DATA_W-1:0] cell_q [DEPTH];

	// Handshake
	assign out_free  = !res_valid_q || !res_stall;
	assign cmd_stall = (state_q != S_IDLE) || !out_free;
	assign cmd_acc   = cmd_valid && !cmd_stall;

	// Walk step: pop the head, push it back at the tail unless it matches the key
	assign head      = cell_q[0];
	assign walk      = (state_q != S_IDLE) && out_free;
	assign last_step = (steps_q == CNT_W'(1));
	assign match     = (state_q == S_DEL) && (head == key_q);
	assign len_next  = len_q - CNT_W'(match);
	assign full      = (count_q == CNT_W'(DEPTH));

	// Cell chain control
	always_comb begin
		cell_ctrl = '0;
		load_idx  = count_q;
		if (walk) begin
			cell_ctrl.shift = 1'b1;
			cell_ctrl.load  = !match;
			cell_ctrl.data  = head;
			load_idx        = len_q - CNT_W'(1);
		end else if (cmd_acc && (cmd.command == CMD_APPEND) && !full) begin
			cell_ctrl.load  = 1'b1;
			cell_ctrl.data  = cmd.value;
		end
	end

	// Result beat for this cycle
	always_comb begin
		new_valid      = 1'b0;
		new_res.item   = '0;
		new_res.status = ST_OK;
		new_res.last   = 1'b1;
		if (walk) begin
			if (state_q == S_SHOW) begin
				new_valid    = 1'b1;
				new_res.item = signed'(head);
				new_res.last = last_step;
			end else if (last_step) begin
				new_valid      = 1'b1;
				new_res.status = (hit_q || match) ? ST_OK : ST_NOT_FOUND;
			end
		end else if (cmd_acc) begin
			unique case (cmd.command)
				CMD_APPEND: begin
					new_valid      = 1'b1;
					new_res.status = full ? ST_FULL : ST_OK;
				end
				CMD_DELETE: begin
					new_valid      = (count_q == '0);
					new_res.status = ST_NOT_FOUND;
				end
				CMD_SHOW: begin
					new_valid      = (count_q == '0);
					new_res.status = ST_EMPTY;
				end
				default: begin
					new_valid = 1'b0;
				end
			endcase
		end
	end

	// Sequencer and list length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			len_q   <= '0;
			steps_q <= '0;
			hit_q   <= 1'b0;
		end else if (walk) begin
			len_q   <= len_next;
			steps_q <= steps_q - CNT_W'(1);
			hit_q   <= hit_q || match;
			if (last_step) begin
				state_q <= S_IDLE;
				count_q <= len_next;
			end
		end else if (cmd_acc) begin
			len_q   <= count_q;
			steps_q <= count_q;
			hit_q   <= 1'b0;
			unique case (cmd.command)
				CMD_APPEND: begin
					if (!full) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				CMD_DELETE: begin
					if (count_q != '0) begin
						state_q <= S_DEL;
					end
				end
				CMD_SHOW: begin
					if (count_q != '0) begin
						state_q <= S_SHOW;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Delete key
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			key_q <= cmd.value;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= new_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			res_q <= new_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Chain of entry cells, cell 0 is the head
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [DATA_W-1:0] right;
		if (g == DEPTH - 1) begin : g_tail
			assign right = cell_q[g];
		end else begin : g_mid
			assign right = cell_q[g+1];
		end
		ola_cell #(
			.IDX   (g),
			.CNT_W (CNT_W)
		) u_cell (
			.clk      (clk),
			.ctrl     (cell_ctrl),
			.load_idx (load_idx),
			.right    (right),
			.q        (cell_q[g])
		);
	end

endmodule

`default_nettype wire

// ===== rtl/core/ola_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module ola_sva (
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_stall,
	input ola_pkg::ola_in_t  cmd,
	input logic              res_valid,
	input logic              res_stall,
	input ola_pkg::ola_out_t res
);
	import ola_pkg::*;

	// A stalled result beat stays up and unchanged
	`AST_NXT(a_res_hold, res_valid && res_stall, res_valid)
	`AST_NXT(a_res_stable, res_valid && res_stall, $stable(res))

	// Error and empty beats carry no item and close the command
	`AST_IMP(a_err_item_zero, res_valid && (res.status != ST_OK), res.item == '0)
	`AST_IMP(a_err_last, res_valid && (res.status != ST_OK), res.last)

	// An accepted append answers with a single closing beat in the next cycle
	`AST_NXT(a_append_resp, cmd_valid && !cmd_stall && (cmd.command == CMD_APPEND),
		res_valid && res.last)

endmodule

bind ordered_list_append_delete ola_sva u_ola_sva (.*);

`default_nettype wire
